FILE: rtl/core/ccar_pkg.sv
// Shared types, widths and coordinate helpers for the closed-contour resampler.
// No dependencies; imported by ccar_sqrt, ccar_div and the top level (not by ccar_ram).
`default_nettype none

package ccar_pkg;

    localparam int COORD_W    = 24;
    localparam int LEN_W      = 32;
    localparam int MAG_W      = 24;
    localparam int SQ_W       = 48;
    localparam int RAD_W      = 50;
    localparam int ROOT_W     = 25;
    // Wide enough for i*L (at most 32 + 11 bits) and |d|*num (24 + 32 bits)
    localparam int DIV_W      = 56;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic [MAG_W-1:0]          mag_t;

    // |b - a| for two Q15.8 coordinates
    function automatic mag_t diff_mag(coord_t a, coord_t b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] nd;
        begin
            d  = {b[COORD_W-1], b} - {a[COORD_W-1], a};
            nd = -d;
            diff_mag = d[COORD_W] ? nd[MAG_W-1:0] : d[MAG_W-1:0];
        end
    endfunction

    function automatic logic diff_neg(coord_t a, coord_t b);
        begin
            diff_neg = (b < a);
        end
    endfunction

    // Move from a by off toward the far point; stays between the two points
    function automatic coord_t step_toward(coord_t a, logic neg, mag_t off);
        logic [COORD_W:0] s;
        begin
            if (neg)
            begin
                s = {a[COORD_W-1], a} - {1'b0, off};
            end
            else
            begin
                s = {a[COORD_W-1], a} + {1'b0, off};
            end
            step_toward = s[COORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ccar_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ccar_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/ccar_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on ccar_pkg.
`default_nettype none

module ccar_sqrt
    import ccar_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic                   done,
    output logic      [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]      rem_reg, rem_next;
    logic [RAD_W-1:0]      res_reg, res_next;
    logic [RAD_W-1:0]      bit_reg, bit_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [RAD_W-1:0]      trial;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            rem_next = radicand;
            res_next = '0;
            bit_next = RAD_W'(1) << (RAD_W - 2);
            cnt_next = ROOT_CNT_W'(ROOT_W);
        end
        else if (cnt_reg != '0)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == ROOT_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/ccar_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ccar_pkg.
`default_nettype none

module ccar_div
    import ccar_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [LEN_W-1:0] divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] quotient
);

    logic [LEN_W:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [LEN_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [LEN_W:0]       shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[LEN_W-1:0], quo_reg[DIV_W-1]};
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = DIV_CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = shifted - {1'b0, dsr_reg};
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/core/closed_contour_arc_length_resampler_top.sv
// Closed-contour arc-length resampler: point RAMs, running-length RAM, sequencer.
// Depends on ccar_pkg, ccar_ram, ccar_sqrt, ccar_div.
// Load: one point per cycle; input stalls from the last point until the burst ends.
// Lengths: each point takes RAM reads, squares and a 25-step square root.
// Each output: segment search and three 56-step divides, only the target divide if degenerate.
// Reset clears the sequencer and point count; RAM contents are never cleared.
`default_nettype none

module closed_contour_arc_length_resampler_top
    import ccar_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [COORD_W-1:0] in_x,
    input  wire logic [COORD_W-1:0] in_y,
    input  wire logic               in_last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [COORD_W-1:0] out_x,
    output logic      [COORD_W-1:0] out_y,
    output logic                    out_last
);

    localparam int PA_W  = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [4:0] {
        S_LOAD,
        S_C_RD1, S_C_RD2, S_C_DIFF, S_C_MUL, S_C_ROOT, S_C_WAIT,
        S_E_TGT, S_E_TWAIT, S_E_RD, S_E_CHK, S_E_RD1, S_E_RD2, S_E_P2,
        S_E_MX, S_E_DX, S_E_WX, S_E_MY, S_E_DY, S_E_WY, S_E_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] j_reg, j_next;
    len_t             total_reg, total_next;
    len_t             target_reg, target_next;
    len_t             d1_reg, d1_next;
    len_t             d2_reg, d2_next;
    len_t             num_reg, num_next;
    len_t             den_reg, den_next;
    logic             degen_reg, degen_next;
    coord_t           p1x_reg, p1x_next, p1y_reg, p1y_next;
    coord_t           p2x_reg, p2x_next, p2y_reg, p2y_next;
    logic [SQ_W-1:0]  sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [DIV_W-1:0] prod_reg, prod_next;
    coord_t           ox_reg, ox_next, oy_reg, oy_next;

    logic             in_acc;
    logic             xy_we;
    logic [PA_W-1:0]  xy_raddr;
    coord_t           x_rdata, y_rdata;
    logic             cum_we;
    logic [CNT_W-1:0] cum_waddr, cum_raddr;
    len_t             cum_wdata, cum_rdata;
    logic             sqrt_start, sqrt_done;
    logic [ROOT_W-1:0] root;
    logic             div_start, div_done;
    logic [DIV_W-1:0] dividend, quotient;
    len_t             divisor;
    logic [LEN_W:0]   sum_wide;
    len_t             sum_sat;
    logic [LEN_W+CNT_W-1:0] tprod;
    logic             idx_at_end;
    logic             j_at_end;
    logic [PA_W-1:0]  idx_succ, j_succ;

    assign in_stall  = (state_reg != S_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (state_reg == S_E_OUT);
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_last  = idx_at_end;

    assign idx_at_end = (idx_reg + 1'b1 == count_reg);
    assign j_at_end   = (j_reg + 1'b1 == count_reg);
    assign idx_succ   = idx_at_end ? '0 : PA_W'(idx_reg + 1'b1);
    assign j_succ     = j_at_end ? '0 : PA_W'(j_reg + 1'b1);

    assign sum_wide = {1'b0, total_reg} + (LEN_W + 1)'(root);
    assign sum_sat  = sum_wide[LEN_W] ? '1 : sum_wide[LEN_W-1:0];
    assign tprod    = (LEN_W + CNT_W)'(idx_reg) * (LEN_W + CNT_W)'(total_reg);

    // Memory and arithmetic unit controls
    always_comb
    begin
        xy_we      = in_acc && (count_reg < CNT_W'(MAX_POINTS));
        cum_we     = 1'b0;
        cum_waddr  = '0;
        cum_wdata  = '0;
        xy_raddr   = PA_W'(idx_reg);
        cum_raddr  = j_reg;
        sqrt_start = (state_reg == S_C_ROOT);
        div_start  = 1'b0;
        dividend   = prod_reg;
        divisor    = den_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                // running length of point 0 is zero
                cum_we = in_acc && in_last;
            end
            S_C_RD1:  xy_raddr = PA_W'(idx_reg);
            S_C_RD2:  xy_raddr = idx_succ;
            S_C_WAIT:
            begin
                cum_we    = sqrt_done;
                cum_waddr = idx_reg + 1'b1;
                cum_wdata = sum_sat;
            end
            S_E_TGT:
            begin
                div_start = 1'b1;
                dividend  = DIV_W'(tprod);
                divisor   = LEN_W'(count_reg);
            end
            S_E_RD:   cum_raddr = j_reg + 1'b1;
            S_E_RD1:
            begin
                cum_raddr = j_reg;
                xy_raddr  = PA_W'(j_reg);
            end
            S_E_RD2:  xy_raddr = j_succ;
            S_E_DX:   div_start = 1'b1;
            S_E_DY:   div_start = 1'b1;
            default:  ;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        j_next      = j_reg;
        total_next  = total_reg;
        target_next = target_reg;
        d1_next     = d1_reg;
        d2_next     = d2_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        degen_next  = degen_reg;
        p1x_next    = p1x_reg;
        p1y_next    = p1y_reg;
        p2x_next    = p2x_reg;
        p2y_next    = p2y_reg;
        sqx_next    = sqx_reg;
        sqy_next    = sqy_reg;
        prod_next   = prod_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (xy_we)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (in_last)
                    begin
                        idx_next   = '0;
                        total_next = '0;
                        state_next = S_C_RD1;
                    end
                end
            end
            S_C_RD1:  state_next = S_C_RD2;
            S_C_RD2:
            begin
                p1x_next   = x_rdata;
                p1y_next   = y_rdata;
                state_next = S_C_DIFF;
            end
            S_C_DIFF:
            begin
                p2x_next   = x_rdata;
                p2y_next   = y_rdata;
                state_next = S_C_MUL;
            end
            S_C_MUL:
            begin
                sqx_next   = SQ_W'(diff_mag(p1x_reg, p2x_reg)) *
                             SQ_W'(diff_mag(p1x_reg, p2x_reg));
                sqy_next   = SQ_W'(diff_mag(p1y_reg, p2y_reg)) *
                             SQ_W'(diff_mag(p1y_reg, p2y_reg));
                state_next = S_C_ROOT;
            end
            S_C_ROOT: state_next = S_C_WAIT;
            S_C_WAIT:
            begin
                if (sqrt_done)
                begin
                    total_next = sum_sat;
                    if (idx_at_end)
                    begin
                        idx_next   = '0;
                        j_next     = '0;
                        state_next = S_E_TGT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_C_RD1;
                    end
                end
            end
            S_E_TGT:  state_next = S_E_TWAIT;
            S_E_TWAIT:
            begin
                if (div_done)
                begin
                    target_next = quotient[LEN_W-1:0];
                    state_next  = S_E_RD;
                end
            end
            S_E_RD:   state_next = S_E_CHK;
            S_E_CHK:
            begin
                // advance while the segment ends at or before the target
                if (!j_at_end && cum_rdata <= target_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_E_RD;
                end
                else
                begin
                    d2_next    = cum_rdata;
                    state_next = S_E_RD1;
                end
            end
            S_E_RD1:  state_next = S_E_RD2;
            S_E_RD2:
            begin
                d1_next    = cum_rdata;
                p1x_next   = x_rdata;
                p1y_next   = y_rdata;
                state_next = S_E_P2;
            end
            S_E_P2:
            begin
                p2x_next   = x_rdata;
                p2y_next   = y_rdata;
                degen_next = (d2_reg <= d1_reg) || (target_reg < d1_reg);
                den_next   = d2_reg - d1_reg;
                num_next   = ((target_reg - d1_reg) > (d2_reg - d1_reg)) ?
                             (d2_reg - d1_reg) : (target_reg - d1_reg);
                state_next = S_E_MX;
            end
            S_E_MX:
            begin
                if (degen_reg)
                begin
                    ox_next    = p1x_reg;
                    oy_next    = p1y_reg;
                    state_next = S_E_OUT;
                end
                else
                begin
                    prod_next  = DIV_W'(diff_mag(p1x_reg, p2x_reg)) * DIV_W'(num_reg);
                    state_next = S_E_DX;
                end
            end
            S_E_DX:   state_next = S_E_WX;
            S_E_WX:
            begin
                if (div_done)
                begin
                    ox_next    = step_toward(p1x_reg, diff_neg(p1x_reg, p2x_reg),
                                             quotient[MAG_W-1:0]);
                    state_next = S_E_MY;
                end
            end
            S_E_MY:
            begin
                prod_next  = DIV_W'(diff_mag(p1y_reg, p2y_reg)) * DIV_W'(num_reg);
                state_next = S_E_DY;
            end
            S_E_DY:   state_next = S_E_WY;
            S_E_WY:
            begin
                if (div_done)
                begin
                    oy_next    = step_toward(p1y_reg, diff_neg(p1y_reg, p2y_reg),
                                             quotient[MAG_W-1:0]);
                    state_next = S_E_OUT;
                end
            end
            S_E_OUT:
            begin
                if (!out_stall)
                begin
                    if (idx_at_end)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_E_TGT;
                    end
                end
            end
            default:  state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            idx_reg   <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg  <= total_next;
        target_reg <= target_next;
        d1_reg     <= d1_next;
        d2_reg     <= d2_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        degen_reg  <= degen_next;
        p1x_reg    <= p1x_next;
        p1y_reg    <= p1y_next;
        p2x_reg    <= p2x_next;
        p2y_reg    <= p2y_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        prod_reg   <= prod_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
    end

    ccar_ram #(
        .WIDTH(COORD_W),
        .DEPTH(MAX_POINTS)
    ) u_x_ram (
        .clk  (clk),
        .we   (xy_we),
        .waddr(count_reg[PA_W-1:0]),
        .wdata(in_x),
        .raddr(xy_raddr),
        .rdata(x_rdata)
    );

    ccar_ram #(
        .WIDTH(COORD_W),
        .DEPTH(MAX_POINTS)
    ) u_y_ram (
        .clk  (clk),
        .we   (xy_we),
        .waddr(count_reg[PA_W-1:0]),
        .wdata(in_y),
        .raddr(xy_raddr),
        .rdata(y_rdata)
    );

    ccar_ram #(
        .WIDTH(LEN_W),
        .DEPTH(MAX_POINTS + 1)
    ) u_cum_ram (
        .clk  (clk),
        .we   (cum_we),
        .waddr(cum_waddr),
        .wdata(cum_wdata),
        .raddr(cum_raddr),
        .rdata(cum_rdata)
    );

    ccar_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .radicand(RAD_W'(sqx_reg) + RAD_W'(sqy_reg)),
        .done    (sqrt_done),
        .root    (root)
    );

    ccar_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(dividend),
        .divisor (divisor),
        .done    (div_done),
        .quotient(quotient)
    );

endmodule

`default_nettype wire
